// ===== design/oct_pkg.sv =====
// Shared types, widths and coefficients of the orthonormal color transform.
package oct_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FracBits    = 14;
  localparam int CoefBits    = 16;
  localparam int OpndBits    = SAMPLE_BITS + 2;
  localparam int ProdBits    = OpndBits + CoefBits;
  localparam int AccBits     = ProdBits + 2;
  localparam int QBits       = AccBits - FracBits;
  localparam int NumChan     = 4;
  localparam int NumTerms    = 3;

  localparam int CfgIdxBits  = 1;
  localparam int CfgDataBits = 2;

  typedef logic signed [OpndBits-1:0] oct_opnd_t;
  typedef logic signed [CoefBits-1:0] oct_coef_t;

  // Q2.14 coefficients
  localparam oct_coef_t KInv3 = 16'sd9459;
  localparam oct_coef_t KInv2 = 16'sd11585;
  localparam oct_coef_t KInv6 = 16'sd6689;
  localparam oct_coef_t KTwo3 = 16'sd13377;
  localparam oct_coef_t KHalf = 16'sd8192;
  localparam oct_coef_t KUnit = 16'sd16384;

  typedef enum logic [1:0] {
    MODE_SINGLE = 2'd0,
    MODE_RGB    = 2'd1,
    MODE_BAYER  = 2'd2
  } oct_mode_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_MODE = 1'd0,
    CFG_DIR  = 1'd1
  } oct_cfg_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] chan0_in;
    logic signed [SAMPLE_BITS-1:0] chan1_in;
    logic signed [SAMPLE_BITS-1:0] chan2_in;
    logic signed [SAMPLE_BITS-1:0] chan3_in;
  } oct_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] chan0_out;
    logic signed [SAMPLE_BITS-1:0] chan1_out;
    logic signed [SAMPLE_BITS-1:0] chan2_out;
    logic signed [SAMPLE_BITS-1:0] chan3_out;
  } oct_out_t;

  // per-stage load enables handed to each output lane
  typedef struct packed {
    logic mul;
    logic sum;
    logic fin;
  } oct_adv_t;

endpackage

// ===== design/orthonormal_color_transform_top.sv =====
// Orthonormal color transform (RGB/YUV and Bayer opponent), top level.
// Takes one pixel per cycle while in_stall_o is low; its registered stages are
// operand selection and pre-adds, one 18x16 multiply per term in each of four
// output lanes, the three-term sum with rounding, then shift and saturation.
// Throughput is one pixel per clock, set by the three multipliers in each lane
// working in their own stage; a stall at the output holds the pipeline and
// bubbles are squeezed out. Configuration (channel mode, direction) is taken
// by the pixel as it enters, so write it while no pixel is in flight.
module orthonormal_color_transform_top import oct_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  oct_in_t                in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output oct_out_t               out_data_o
);

  logic [1:0] mode_q;
  logic       dir_q;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  oct_adv_t adv;

  oct_opnd_t x0, x1, x2, x3;
  oct_opnd_t opnd_d [NumChan][NumTerms];
  oct_coef_t coef_d [NumChan][NumTerms];
  oct_opnd_t opnd_q [NumChan][NumTerms];
  oct_coef_t coef_q [NumChan][NumTerms];
  logic signed [SAMPLE_BITS-1:0] res [NumChan];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RGB;
      dir_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (oct_cfg_e'(cfg_idx_i))
        CFG_MODE: mode_q <= cfg_data_i[1:0];
        CFG_DIR:  dir_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when it is empty or its successor loads
  assign en4 = !v4_q || !out_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  assign adv.mul = en2;
  assign adv.sum = en3;
  assign adv.fin = en4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  assign x0 = OpndBits'(in_data_i.chan0_in);
  assign x1 = OpndBits'(in_data_i.chan1_in);
  assign x2 = OpndBits'(in_data_i.chan2_in);
  assign x3 = OpndBits'(in_data_i.chan3_in);

  // operand and coefficient selection; unused terms carry a zero coefficient
  always_comb begin
    for (int l = 0; l < NumChan; l++) begin
      for (int k = 0; k < NumTerms; k++) begin
        opnd_d[l][k] = '0;
        coef_d[l][k] = '0;
      end
    end
    unique case (oct_mode_e'(mode_q))
      MODE_RGB: begin
        if (dir_q) begin
          opnd_d[0][0] = x0 + x1 + x2;           coef_d[0][0] = KInv3;
          opnd_d[1][0] = x0 - x2;                coef_d[1][0] = KInv2;
          opnd_d[2][0] = x0 - (x1 <<< 1) + x2;   coef_d[2][0] = KInv6;
        end else begin
          opnd_d[0][0] = x0; coef_d[0][0] = KInv3;
          opnd_d[0][1] = x1; coef_d[0][1] = KInv2;
          opnd_d[0][2] = x2; coef_d[0][2] = KInv6;
          opnd_d[1][0] = x0; coef_d[1][0] = KInv3;
          opnd_d[1][1] = x2; coef_d[1][1] = -KTwo3;
          opnd_d[2][0] = x0; coef_d[2][0] = KInv3;
          opnd_d[2][1] = x1; coef_d[2][1] = -KInv2;
          opnd_d[2][2] = x2; coef_d[2][2] = KInv6;
        end
      end
      MODE_BAYER: begin
        if (dir_q) begin
          opnd_d[0][0] = x0 + x1 + x2 + x3;      coef_d[0][0] = KHalf;
          opnd_d[1][0] = x1 - x2;                coef_d[1][0] = KInv2;
          opnd_d[2][0] = x1 + x2 - x0 - x3;      coef_d[2][0] = KHalf;
          opnd_d[3][0] = x3 - x0;                coef_d[3][0] = KInv2;
        end else begin
          opnd_d[0][0] = x0 - x2; coef_d[0][0] = KHalf;
          opnd_d[0][1] = x3;      coef_d[0][1] = -KInv2;
          opnd_d[1][0] = x0 + x2; coef_d[1][0] = KHalf;
          opnd_d[1][1] = x1;      coef_d[1][1] = KInv2;
          opnd_d[2][0] = x0 + x2; coef_d[2][0] = KHalf;
          opnd_d[2][1] = x1;      coef_d[2][1] = -KInv2;
          opnd_d[3][0] = x0 - x2; coef_d[3][0] = KHalf;
          opnd_d[3][1] = x3;      coef_d[3][1] = KInv2;
        end
      end
      default: begin
        // pass-through as a multiply by one
        opnd_d[0][0] = x0; coef_d[0][0] = KUnit;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      opnd_q <= opnd_d;
      coef_q <= coef_d;
    end
  end

  for (genvar l = 0; l < NumChan; l++) begin : g_lane
    oct_lane u_lane (
      .clk_i  (clk_i),
      .adv_i  (adv),
      .opnd_i (opnd_q[l]),
      .coef_i (coef_q[l]),
      .res_o  (res[l])
    );
  end

  assign out_valid_o          = v4_q;
  assign out_data_o.chan0_out = res[0];
  assign out_data_o.chan1_out = res[1];
  assign out_data_o.chan2_out = res[2];
  assign out_data_o.chan3_out = res[3];

  // input is held off only when every stage holds a pixel
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q))
    else $error("input stalled with a bubble in the pipeline");

  a_last_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && en4) |=> v4_q)
    else $error("pixel lost between sum and output stage");

  a_first_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !en2) |=> v1_q)
    else $error("blocked pixel dropped from first stage");

endmodule

// ===== design/oct_lane.sv =====
// One output channel: three multiplies, sum with rounding, shift and saturate.
module oct_lane import oct_pkg::*; (
  input  logic                          clk_i,
  input  oct_adv_t                      adv_i,
  input  oct_opnd_t                     opnd_i [NumTerms],
  input  oct_coef_t                     coef_i [NumTerms],
  output logic signed [SAMPLE_BITS-1:0] res_o
);

  localparam logic signed [AccBits-1:0] Round = AccBits'(1) <<< (FracBits - 1);
  localparam logic signed [SAMPLE_BITS-1:0] MaxS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] MinS = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [ProdBits-1:0]    prod_q [NumTerms];
  logic signed [AccBits-1:0]     acc_d, acc_q;
  logic signed [QBits-1:0]       quo;
  logic [QBits-SAMPLE_BITS:0]    top_bits;
  logic signed [SAMPLE_BITS-1:0] res_d, res_q;

  always_ff @(posedge clk_i) begin
    if (adv_i.mul) begin
      for (int k = 0; k < NumTerms; k++) begin
        prod_q[k] <= opnd_i[k] * coef_i[k];
      end
    end
  end

  always_comb begin
    acc_d = Round;
    for (int k = 0; k < NumTerms; k++) begin
      acc_d = acc_d + AccBits'(prod_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.sum) begin
      acc_q <= acc_d;
    end
  end

  // floor of the rounded sum; fits when the bits above the sample are all sign
  assign quo      = signed'(acc_q[AccBits-1:FracBits]);
  assign top_bits = quo[QBits-1:SAMPLE_BITS-1];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      res_d = quo[SAMPLE_BITS-1:0];
    end else if (quo[QBits-1]) begin
      res_d = MinS;
    end else begin
      res_d = MaxS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.fin) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the orthonormal color transform top level.
`timescale 1ns / 1ps

module tb;
  import oct_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [CfgDataBits-1:0] DIR_INV = 2'd0;
  localparam logic [CfgDataBits-1:0] DIR_FWD = 2'd1;

  localparam longint C_INV3 = 9459;
  localparam longint C_INV2 = 11585;
  localparam longint C_INV6 = 6689;
  localparam longint C_TWO3 = 13377;
  localparam longint C_HALF = 8192;
  localparam int     Q_FRAC = 14;
  localparam longint S_HI   = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint S_LO   = -S_HI - 1;

  localparam logic [SAMPLE_BITS-1:0] SMAX = 16'h7fff;
  localparam logic [SAMPLE_BITS-1:0] SMIN = 16'h8000;

  localparam int SETTLE      = 8;
  localparam int DRAIN_LIMIT = 20000;
  localparam int PRINT_CAP   = 60;

  typedef enum logic [1:0] {
    JOB_PIXEL,
    JOB_CFG,
    JOB_DRAIN
  } job_kind_e;

  typedef struct packed {
    job_kind_e                kind;
    oct_in_t                  pixel;
    oct_cfg_e                 idx;
    logic [CfgDataBits-1:0]   val;
  } job_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  oct_in_t                in_data_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  oct_out_t               out_data_o;

  orthonormal_color_transform_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  job_t     job_q[$];
  oct_out_t expected_pixels[$];
  int       mismatch_count = 0;
  int       pixels_checked = 0;

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  // Q.14 accumulator -> nearest (ties up), then clamp to the sample range
  function automatic logic [SAMPLE_BITS-1:0] round_sat(input longint acc);
    longint q;
    q = (acc + (longint'(1) << (Q_FRAC - 1))) >>> Q_FRAC;
    if (q > S_HI) q = S_HI;
    else if (q < S_LO) q = S_LO;
    return q[SAMPLE_BITS-1:0];
  endfunction

  function automatic oct_out_t transform_pixel(input oct_in_t px, input logic [1:0] mode,
                                               input logic fwd);
    longint x0, x1, x2, x3;
    oct_out_t r;
    x0 = longint'(px.chan0_in);
    x1 = longint'(px.chan1_in);
    x2 = longint'(px.chan2_in);
    x3 = longint'(px.chan3_in);
    r = '0;
    case (mode)
      MODE_RGB: begin
        if (fwd) begin
          r.chan0_out = round_sat(C_INV3 * (x0 + x1 + x2));
          r.chan1_out = round_sat(C_INV2 * (x0 - x2));
          r.chan2_out = round_sat(C_INV6 * (x0 - 2 * x1 + x2));
        end else begin
          r.chan0_out = round_sat(C_INV3 * x0 + C_INV2 * x1 + C_INV6 * x2);
          r.chan1_out = round_sat(C_INV3 * x0 - C_TWO3 * x2);
          r.chan2_out = round_sat(C_INV3 * x0 - C_INV2 * x1 + C_INV6 * x2);
        end
      end
      MODE_BAYER: begin
        if (fwd) begin
          r.chan0_out = round_sat(C_HALF * (x0 + x1 + x2 + x3));
          r.chan1_out = round_sat(C_INV2 * (x1 - x2));
          r.chan2_out = round_sat(C_HALF * (-x0 + x1 + x2 - x3));
          r.chan3_out = round_sat(C_INV2 * (x3 - x0));
        end else begin
          r.chan0_out = round_sat(C_HALF * x0 - C_HALF * x2 - C_INV2 * x3);
          r.chan1_out = round_sat(C_HALF * x0 + C_INV2 * x1 + C_HALF * x2);
          r.chan2_out = round_sat(C_HALF * x0 - C_INV2 * x1 + C_HALF * x2);
          r.chan3_out = round_sat(C_HALF * x0 - C_HALF * x2 + C_INV2 * x3);
        end
      end
      default: r.chan0_out = px.chan0_in;
    endcase
    return r;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return SMAX;
      1: return SMIN;
      2, 3: return SAMPLE_BITS'($urandom_range(0, 127) - 64);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic queue_pixel(input oct_in_t px);
    job_t j;
    j = '0;
    j.kind = JOB_PIXEL;
    j.pixel = px;
    job_q.push_back(j);
  endtask

  task automatic queue_cfg(input oct_cfg_e idx, input logic [CfgDataBits-1:0] val);
    job_t j;
    j = '0;
    j.kind = JOB_CFG;
    j.idx = idx;
    j.val = val;
    job_q.push_back(j);
  endtask

  task automatic queue_drain();
    job_t j;
    j = '0;
    j.kind = JOB_DRAIN;
    job_q.push_back(j);
  endtask

  // Sender: bursts of transfers with random gaps; config writes and drains
  // wait for an empty pipeline.
  job_t                   cur_job;
  logic                   have_pixel = 1'b0;
  int                     burst_left = 0;
  int                     gap_left = 0;
  int                     idle_cnt = 0;
  logic                   sent;
  logic                   nxt_valid;
  oct_in_t                nxt_pixel;
  logic                   nxt_we;
  logic [CfgIdxBits-1:0]  nxt_idx;
  logic [CfgDataBits-1:0] nxt_val;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      sent = in_valid_i && !in_stall_o;
      if (sent) have_pixel = 1'b0;
      nxt_valid = in_valid_i && !sent;
      nxt_pixel = in_data_i;
      nxt_we = 1'b0;
      nxt_idx = cfg_idx_i;
      nxt_val = cfg_data_i;
      if (!have_pixel && job_q.size() != 0) begin
        cur_job = job_q[0];
        if (cur_job.kind == JOB_PIXEL) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            void'(job_q.pop_front());
            nxt_valid = 1'b1;
            nxt_pixel = cur_job.pixel;
            have_pixel = 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
              burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
              gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
          end
        end else if (sent || expected_pixels.size() != 0) begin
          idle_cnt = 0;
        end else if (idle_cnt < SETTLE) begin
          idle_cnt++;
        end else begin
          idle_cnt = 0;
          void'(job_q.pop_front());
          if (cur_job.kind == JOB_CFG) begin
            nxt_we = 1'b1;
            nxt_idx = cur_job.idx;
            nxt_val = cur_job.val;
          end
        end
      end
      in_valid_i <= nxt_valid;
      in_data_i <= nxt_pixel;
      cfg_we_i <= nxt_we;
      cfg_idx_i <= nxt_idx;
      cfg_data_i <= nxt_val;
    end
  end

  // Predict on each input transfer, check each output transfer, drive stall.
  logic [1:0] cur_mode = MODE_RGB;
  logic       cur_fwd = 1'b1;
  int         stall_tick = 0;
  int         stall_style = 0;
  logic       nxt_stall;
  oct_out_t   want;
  logic [SAMPLE_BITS-1:0] got_s, want_s;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cur_mode = MODE_RGB;
      cur_fwd = 1'b1;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MODE) cur_mode = cfg_data_i[1:0];
        else cur_fwd = cfg_data_i[0];
      end
      if (in_valid_i && !in_stall_o)
        expected_pixels.push_back(transform_pixel(in_data_i, cur_mode, cur_fwd));
      if (out_valid_o && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing expected", out_data_o));
        end else begin
          want = expected_pixels.pop_front();
          for (int ch = 0; ch < NumChan; ch++) begin
            got_s = out_data_o[(NumChan - 1 - ch) * SAMPLE_BITS +: SAMPLE_BITS];
            want_s = want[(NumChan - 1 - ch) * SAMPLE_BITS +: SAMPLE_BITS];
            if (got_s !== want_s)
              report_mismatch($sformatf("pixel %0d chan%0d got %0d expected %0d",
                                        pixels_checked, ch, $signed(got_s),
                                        $signed(want_s)));
          end
          pixels_checked++;
        end
      end
      stall_tick++;
      if (stall_tick % 200 == 0) stall_style = $urandom_range(0, 3);
      case (stall_style)
        0: nxt_stall = 1'b0;
        1: nxt_stall = ($urandom_range(0, 3) == 0);
        2: nxt_stall = ($urandom_range(0, 3) != 0);
        default: nxt_stall = stall_tick[3];
      endcase
      out_stall_i <= nxt_stall;
    end
  end

  initial begin
    oct_in_t    corner [6];
    oct_in_t    px;
    logic [1:0] phase_mode [10];
    int         k;

    corner[0] = '0;
    corner[1] = {4{SMAX}};
    corner[2] = {4{SMIN}};
    corner[3] = {SMAX, SMIN, SMAX, SMIN};
    corner[4] = {SMIN, SMAX, SMIN, SMAX};
    corner[5] = {16'h0001, 16'hffff, 16'h0010, 16'hfff0};

    // directed: corners through every mode and direction, reset config first
    for (int i = 0; i < 6; i++) queue_pixel(corner[i]);
    queue_cfg(CFG_DIR, DIR_INV);
    for (int i = 0; i < 5; i++) queue_pixel(corner[i]);
    queue_cfg(CFG_MODE, MODE_BAYER);
    for (int i = 0; i < 5; i++) queue_pixel(corner[i]);
    queue_cfg(CFG_DIR, DIR_FWD);
    for (int i = 0; i < 5; i++) queue_pixel(corner[i]);
    queue_cfg(CFG_MODE, MODE_SINGLE);
    queue_pixel(corner[3]);
    queue_pixel(corner[5]);

    // random phases; direction data uses all codes so the unused bit is hit
    phase_mode = '{MODE_RGB, MODE_BAYER, MODE_SINGLE, MODE_BAYER, MODE_RGB,
                   MODE_SPARE, MODE_BAYER, MODE_RGB, MODE_BAYER, MODE_RGB};
    for (int ph = 0; ph < 10; ph++) begin
      queue_cfg(CFG_MODE, phase_mode[ph]);
      queue_cfg(CFG_DIR, CfgDataBits'($urandom_range(0, 3)));
      for (int n = 0; n < 60; n++) begin
        if (n == 30 && (ph == 0 || $urandom_range(0, 2) == 0)) queue_drain();
        px.chan0_in = rand_sample();
        px.chan1_in = rand_sample();
        px.chan2_in = rand_sample();
        px.chan3_in = rand_sample();
        queue_pixel(px);
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait on after the queue empties so the last input transfer is already predicted
    while (job_q.size() != 0 || have_pixel) @(posedge clk_i);
    @(posedge clk_i);
    for (k = 0; k < DRAIN_LIMIT && expected_pixels.size() != 0; k++) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (expected_pixels.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
